@@ hw/rtl/rhni_pkg.sv @@
// Shared types, opcodes and hazard check functions for the RAW hazard NOP inserter.
`default_nettype none

package rhni_pkg;

  localparam logic [31:0] NOP_WORD  = 32'h0000_0033;

  localparam logic [6:0]  OP_R      = 7'h33;
  localparam logic [6:0]  OP_B      = 7'h63;
  localparam logic [6:0]  OP_S      = 7'h23;
  localparam logic [6:0]  OP_J      = 7'h6F;
  localparam logic [6:0]  OP_AUIPC  = 7'h17;
  localparam logic [6:0]  OP_LUI    = 7'h37;

  typedef enum logic [2:0] {
    FMT_R,
    FMT_I,
    FMT_S,
    FMT_B,
    FMT_U,
    FMT_J
  } fmt_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  nops;
    logic        last;
  } entry_t;

  function automatic fmt_t classify(input logic [31:0] w);
    fmt_t f;
    case (w[6:0])
      OP_R:              f = FMT_R;
      OP_B:              f = FMT_B;
      OP_S:              f = FMT_S;
      OP_J:              f = FMT_J;
      OP_AUIPC, OP_LUI:  f = FMT_U;
      default:           f = FMT_I;
    endcase
    return f;
  endfunction

  function automatic logic conflicts(input logic [4:0] prod_rd, input logic [31:0] cons);
    fmt_t f;
    logic hit;
    f = classify(cons);
    case (f)
      FMT_U, FMT_J: hit = (cons[11:7] == prod_rd);
      FMT_I:        hit = (cons[19:15] == prod_rd);
      default:      hit = (cons[19:15] == prod_rd) || (cons[24:20] == prod_rd);
    endcase
    return hit;
  endfunction

  function automatic logic [1:0] nop_count(input logic [31:0] w, input logic has_a,
                                           input logic [31:0] a, input logic has_b,
                                           input logic [31:0] b);
    fmt_t f;
    logic [1:0] n;
    f = classify(w);
    n = 2'd0;
    if ((f == FMT_R || f == FMT_I) && has_a) begin
      if (conflicts(w[11:7], a)) begin
        n = 2'd2;
      end else if (has_b && conflicts(w[11:7], b)) begin
        n = 2'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rhni_front.sv @@
// Front end: holds the instruction window, classifies the oldest word and queues it.
`default_nettype none

module rhni_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [31:0]     instr_word,
  input  wire logic            last_item,
  input  wire logic            q_full,
  output logic                 q_push,
  output rhni_pkg::entry_t     q_entry
);
  import rhni_pkg::*;

  logic [31:0] win [3];
  logic [31:0] win_next [3];
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        flushing;
  logic        flushing_next;
  logic        accept;
  logic [1:0]  widx;

  always_comb begin
    q_push   = !q_full && (count == 2'd3 || (flushing && count != 2'd0));
    in_stall = flushing || (count == 2'd3 && !q_push);
    accept   = in_valid && !in_stall;

    q_entry.word = win[0];
    q_entry.nops = nop_count(win[0], count >= 2'd2, win[1], count == 2'd3, win[2]);
    q_entry.last = flushing && count == 2'd1;

    widx = count - {1'b0, q_push};
    count_next = widx + {1'b0, accept};

    flushing_next = flushing;
    if (accept && last_item) begin
      flushing_next = 1'b1;
    end else if (q_push && flushing && count == 2'd1) begin
      flushing_next = 1'b0;
    end

    win_next[0] = q_push ? win[1] : win[0];
    win_next[1] = q_push ? win[2] : win[1];
    win_next[2] = win[2];
    for (int i = 0; i < 3; i++) begin
      if (accept && widx == 2'(i)) begin
        win_next[i] = instr_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= 2'd0;
      flushing <= 1'b0;
    end else begin
      count    <= count_next;
      flushing <= flushing_next;
    end
    for (int i = 0; i < 3; i++) begin
      win[i] <= win_next[i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rhni_queue.sv @@
// Short queue of classified words between the front and back ends.
`default_nettype none

module rhni_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rhni_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output rhni_pkg::entry_t       head,
  output logic                   empty
);
  import rhni_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rhni_back.sv @@
// Back end: sends each queued word, then its NOP beats, through the output register.
`default_nettype none

module rhni_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rhni_pkg::entry_t  head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_word,
  output logic                   is_nop,
  output logic                   last_out
);
  import rhni_pkg::*;

  logic [1:0] rem;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign q_pop     = slot_free && rem == 2'd0 && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= 2'd0;
    end else if (slot_free) begin
      if (rem != 2'd0) begin
        out_valid <= 1'b1;
        rem       <= rem - 2'd1;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        rem       <= head.nops;
      end else begin
        out_valid <= 1'b0;
      end
    end
    if (slot_free) begin
      if (rem != 2'd0) begin
        out_word <= NOP_WORD;
        is_nop   <= 1'b1;
        last_out <= 1'b0;
      end else begin
        out_word <= head.word;
        is_nop   <= 1'b0;
        last_out <= head.last;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/raw_hazard_nop_inserter.sv @@
// Top level of the RAW hazard NOP inserter: front end, queue and back end.
//
//   channel  signals                              direction
//   in       in_valid, in_stall, instr_word,      words in
//            last_item
//   out      out_valid, out_stall, out_word,      words out
//            is_nop, last_out
//
// The front takes one input beat a cycle unless in_stall is high; each word
// leaves as one to three output beats, one a cycle while out_stall is low,
// paced by the back end's NOP sequencer, so long hazard runs back up to in_stall.
// A beat with last_item holds in_stall high while the held window drains
// into the queue, and longer while the queue is full.
// Reset is synchronous and clears all counts and valids; held words are
// undefined until written. out_stall backs up through the queue to in_stall.
`default_nettype none

module raw_hazard_nop_inserter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] instr_word,
  input  wire logic        last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_word,
  output logic             is_nop,
  output logic             last_out
);
  import rhni_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  rhni_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .instr_word (instr_word),
    .last_item  (last_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  rhni_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty)
  );

  rhni_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .is_nop    (is_nop),
    .last_out  (last_out)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rhni_checker.sv @@
// Port-level checks for the RAW hazard NOP inserter, bound to the top level.
`default_nettype none

module rhni_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [31:0] instr_word,
  input wire logic        last_item,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_word,
  input wire logic        is_nop,
  input wire logic        last_out
);
  import rhni_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(instr_word) && $stable(last_item))
    else $error("stalled input beat changed");

  a_nop_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_nop |-> out_word == NOP_WORD)
    else $error("inserted beat is not the NOP word");

  a_nop_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_nop && last_out))
    else $error("inserted NOP marked as final beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(is_nop)
      && $stable(last_out))
    else $error("stalled output beat changed");

endmodule

bind raw_hazard_nop_inserter rhni_checker u_rhni_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .instr_word (instr_word),
  .last_item  (last_item),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_word   (out_word),
  .is_nop     (is_nop),
  .last_out   (last_out)
);

`default_nettype wire

@@ tb/hazard_stream_checker.sv @@
// Checker for the RAW hazard NOP inserter: predicts the output stream and compares it.
`default_nettype none

module hazard_stream_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] instr_word,
  input  wire logic        last_item,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_word,
  input  wire logic        is_nop,
  input  wire logic        last_out,
  output int               mismatches,
  output int               pending
);
  import rhni_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        nop;
    logic        last;
  } beat_t;

  beat_t       due_q[$];
  logic [31:0] win_old;
  logic [31:0] win_new;
  int          win_n = 0;

  function automatic fmt_t kind_of(input logic [31:0] w);
    if (w[6:0] == OP_R) return FMT_R;
    if (w[6:0] == OP_B) return FMT_B;
    if (w[6:0] == OP_S) return FMT_S;
    if (w[6:0] == OP_J) return FMT_J;
    if (w[6:0] == OP_AUIPC || w[6:0] == OP_LUI) return FMT_U;
    return FMT_I;
  endfunction

  function automatic bit reads_rd(input logic [4:0] rd, input logic [31:0] c);
    fmt_t k;
    k = kind_of(c);
    if (k == FMT_U || k == FMT_J) return c[11:7] == rd;
    if (k == FMT_I) return c[19:15] == rd;
    return (c[19:15] == rd) || (c[24:20] == rd);
  endfunction

  task automatic emit_word(input logic [31:0] w, input bit has_a, input logic [31:0] a,
                           input bit has_b, input logic [31:0] b, input bit fin);
    fmt_t k;
    int   n;
    k = kind_of(w);
    n = 0;
    due_q.push_back('{w, 1'b0, fin});
    if ((k == FMT_R || k == FMT_I) && has_a) begin
      if (reads_rd(w[11:7], a)) begin
        n = 2;
      end else if (has_b && reads_rd(w[11:7], b)) begin
        n = 1;
      end
    end
    repeat (n) due_q.push_back('{NOP_WORD, 1'b1, 1'b0});
  endtask

  task automatic take_word(input logic [31:0] w, input bit fin);
    if (!fin) begin
      if (win_n == 2) begin
        emit_word(win_old, 1'b1, win_new, 1'b1, w, 1'b0);
        win_old = win_new;
        win_new = w;
      end else if (win_n == 1) begin
        win_new = w;
        win_n   = 2;
      end else begin
        win_old = w;
        win_n   = 1;
      end
    end else begin
      // flush the held window, then the closing word
      if (win_n == 2) begin
        emit_word(win_old, 1'b1, win_new, 1'b1, w, 1'b0);
        emit_word(win_new, 1'b1, w, 1'b0, '0, 1'b0);
      end else if (win_n == 1) begin
        emit_word(win_old, 1'b1, w, 1'b0, '0, 1'b0);
      end
      emit_word(w, 1'b0, '0, 1'b0, '0, 1'b1);
      win_n = 0;
    end
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < 40) begin
      $display("mismatch %s: got %h, want %h", field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    beat_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        take_word(instr_word, last_item);
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report("unexpected beat", out_word, '0);
        end else begin
          want = due_q.pop_front();
          if (out_word !== want.word) report("out_word", out_word, want.word);
          if (is_nop !== want.nop) report("is_nop", 32'(is_nop), 32'(want.nop));
          if (last_out !== want.last) report("last_out", 32'(last_out), 32'(want.last));
        end
      end
    end
    pending = due_q.size();
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench top for the RAW hazard NOP inserter: clock, reset, stimulus and verdict.
`default_nettype none

module tb;
  import rhni_pkg::*;

  localparam logic [6:0] OP_IMM  = 7'h13;
  localparam logic [6:0] OP_LOAD = 7'h03;
  localparam logic [6:0] OP_JALR = 7'h67;
  localparam int         LIMIT   = 400000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [31:0] instr_word = '0;
  logic        last_item  = 1'b0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_word;
  logic        is_nop;
  logic        last_out;

  int mismatches;
  int pending;
  int cycles = 0;
  int sent   = 0;
  bit calm   = 1'b0;

  always #1 clk = ~clk;

  raw_hazard_nop_inserter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .instr_word (instr_word),
    .last_item  (last_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .is_nop     (is_nop),
    .last_out   (last_out)
  );

  hazard_stream_checker u_stream_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .instr_word (instr_word),
    .last_item  (last_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .is_nop     (is_nop),
    .last_out   (last_out),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 20);
  end

  function automatic logic [31:0] enc(input logic [6:0] op, input logic [4:0] rd,
                                      input logic [4:0] rs1, input logic [4:0] rs2);
    return {7'b0, rs2, rs1, 3'b0, rd, op};
  endfunction

  // favor a few registers so hazards are common
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) != 0) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] pick_word();
    logic [6:0] op;
    case ($urandom_range(0, 9))
      0, 1:    op = OP_R;
      2:       op = OP_IMM;
      3:       op = OP_LOAD;
      4:       op = OP_JALR;
      5:       op = OP_S;
      6:       op = OP_B;
      7:       op = $urandom_range(0, 1) ? OP_LUI : OP_AUIPC;
      8:       op = OP_J;
      default: op = 7'($urandom);
    endcase
    return enc(op, pick_reg(), pick_reg(), pick_reg()) | ($urandom & 32'hFE00_7000);
  endfunction

  task automatic send(input logic [31:0] w, input bit fin);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    instr_word <= w;
    last_item  <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  initial begin : stimulus
    int  len;
    bit  paused;
    paused = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(enc(OP_R, 5, 0, 0), 1'b1);
    send(enc(OP_IMM, 3, 0, 0), 1'b0);
    send(enc(OP_R, 9, 7, 3), 1'b0);
    send(enc(OP_B, 0, 9, 1), 1'b0);
    send(enc(OP_LUI, 4, 0, 0), 1'b0);
    send(enc(OP_LOAD, 6, 0, 0), 1'b0);
    send(enc(OP_S, 0, 1, 2), 1'b0);
    send(enc(OP_J, 6, 0, 0), 1'b0);
    send(enc(OP_JALR, 0, 0, 0), 1'b0);
    send(enc(OP_AUIPC, 0, 0, 0), 1'b0);
    send(enc(OP_R, 31, 31, 31), 1'b0);
    send(enc(OP_IMM, 31, 31, 0), 1'b0);
    send(32'hFFFF_FFFF, 1'b1);
    send(32'h0000_0000, 1'b0);
    send(enc(OP_IMM, 8, 1, 0), 1'b0);
    send(enc(OP_R, 0, 2, 0), 1'b1);
    send(enc(OP_LUI, 10, 0, 0), 1'b0);
    send(enc(OP_R, 11, 10, 10), 1'b1);
    send(enc(OP_R, 12, 0, 0), 1'b0);
    send(enc(OP_S, 12, 1, 1), 1'b0);
    send(enc(OP_B, 0, 3, 12), 1'b1);
    send(enc(OP_R, 20, 0, 0), 1'b0);
    send(enc(OP_R, 21, 20, 0), 1'b1);

    while (sent < 480) begin
      calm = (sent >= 200 && sent < 300);
      if (!paused && sent >= 350) begin
        // hold off until the output side drains
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        for (int i = 0; i < len; i++) begin
          send(pick_word(), i == len - 1);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send($urandom, $urandom_range(0, 9) == 0);
        end
      end
    end
    calm = 1'b0;
    send(pick_word(), 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/rhni_pkg.sv
hw/rtl/rhni_front.sv
hw/rtl/rhni_queue.sv
hw/rtl/rhni_back.sv
hw/rtl/raw_hazard_nop_inserter.sv
hw/rtl/rhni_checker.sv
tb/hazard_stream_checker.sv
tb/tb.sv
